[src/hcm_pkg.sv]
// Shared codes and control/status structs for the chained hash multimap.
`timescale 1ns / 1ps
`default_nettype none
package hcm_pkg;

    // Operation codes carried in the input beat
    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_SEARCH = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;

    // Width of the bucket count register
    localparam int CFG_W = 5;
    localparam logic [CFG_W-1:0] BUCKET_RESET = 5'd10;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic       clr_step;   // clear one bucket head
        logic       accept;     // latch input beat, start modulo
        logic       mod_step;   // one restoring-division step
        logic       rd_head;    // read bucket head and link of free node
        logic       add_wr;     // link new node at chain head
        logic       walk_init;  // start chain walk at head
        logic       rd_node;    // read key/value/link of current node
        logic       adv;        // move to next node
        logic       set_pend;   // hold current value as pending hit
        logic       rem_a;      // bypass node from predecessor or head
        logic       rem_b;      // return node to free list
        logic       emit;       // load output register
        logic [1:0] emit_st;
        logic       emit_pend;  // output carries pending value
        logic       emit_last;
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic       clr_done;
        logic       mod_done;
        logic       out_busy;
        logic [1:0] op;
        logic       free_nil;
        logic       walk_end;
        logic       key_eq;
        logic       val_eq;
        logic       have_pend;
    } t_sts;

endpackage
`default_nettype wire

[src/hcm_ctrl.sv]
// Controller state machine of the chained hash multimap.
`timescale 1ns / 1ps
`default_nettype none
module hcm_ctrl
    import hcm_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);

    typedef enum logic [10:0] {
        S_CLR  = 11'b00000000001,
        S_IDLE = 11'b00000000010,
        S_MOD  = 11'b00000000100,
        S_HEAD = 11'b00000001000,
        S_DISP = 11'b00000010000,
        S_RD   = 11'b00000100000,
        S_CHK  = 11'b00001000000,
        S_REM1 = 11'b00010000000,
        S_REM2 = 11'b00100000000,
        S_END  = 11'b01000000000,
        S_SPARE = 11'b10000000000
    } t_state;

    t_state r_state, n_state;

    assign o_in_ready = (r_state == S_IDLE);

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_CLR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_done) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_MOD;
                end
            end
            S_MOD: begin
                if (i_sts.mod_done) n_state = S_HEAD;
                else o_cmd.mod_step = 1'b1;
            end
            S_HEAD: begin
                o_cmd.rd_head = 1'b1;
                n_state       = S_DISP;
            end
            S_DISP: begin
                unique case (i_sts.op) inside
                    OP_ADD: begin
                        if (!i_sts.out_busy) begin
                            o_cmd.emit      = 1'b1;
                            o_cmd.emit_last = 1'b1;
                            if (i_sts.free_nil) begin
                                o_cmd.emit_st = ST_FULL;
                            end else begin
                                o_cmd.emit_st = ST_OK;
                                o_cmd.add_wr  = 1'b1;
                            end
                            n_state = S_IDLE;
                        end
                    end
                    OP_SEARCH, OP_REMOVE: begin
                        o_cmd.walk_init = 1'b1;
                        n_state         = S_RD;
                    end
                    default: n_state = S_END;
                endcase
            end
            S_RD: begin
                if (i_sts.walk_end) begin
                    n_state = S_END;
                end else begin
                    o_cmd.rd_node = 1'b1;
                    n_state       = S_CHK;
                end
            end
            S_CHK: begin
                if (i_sts.op == OP_SEARCH) begin
                    if (i_sts.key_eq) begin
                        // previous hit goes out once a newer one shows up
                        if (!(i_sts.have_pend && i_sts.out_busy)) begin
                            if (i_sts.have_pend) begin
                                o_cmd.emit      = 1'b1;
                                o_cmd.emit_st   = ST_OK;
                                o_cmd.emit_pend = 1'b1;
                            end
                            o_cmd.set_pend = 1'b1;
                            o_cmd.adv      = 1'b1;
                            n_state        = S_RD;
                        end
                    end else begin
                        o_cmd.adv = 1'b1;
                        n_state   = S_RD;
                    end
                end else begin
                    if (i_sts.key_eq && i_sts.val_eq) begin
                        n_state = S_REM1;
                    end else begin
                        o_cmd.adv = 1'b1;
                        n_state   = S_RD;
                    end
                end
            end
            S_REM1: begin
                o_cmd.rem_a = 1'b1;
                n_state     = S_REM2;
            end
            S_REM2: begin
                if (!i_sts.out_busy) begin
                    o_cmd.rem_b     = 1'b1;
                    o_cmd.emit      = 1'b1;
                    o_cmd.emit_st   = ST_OK;
                    o_cmd.emit_last = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            S_END: begin
                if (!i_sts.out_busy) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.emit_last = 1'b1;
                    if (i_sts.op == OP_SEARCH && i_sts.have_pend) begin
                        o_cmd.emit_st   = ST_OK;
                        o_cmd.emit_pend = 1'b1;
                    end else begin
                        o_cmd.emit_st = ST_NOT_FOUND;
                    end
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule
`default_nettype wire

[src/hcm_dp.sv]
// Datapath: modulo unit, bucket/node memories, walk registers, output register.
`timescale 1ns / 1ps
`default_nettype none
module hcm_dp
    import hcm_pkg::*;
#(
    parameter int MAX_BUCKETS = 16,
    parameter int POOL_NODES  = 32
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_wr_en,
    input  wire logic [CFG_W-1:0] i_cfg_wr_data,
    input  wire logic [1:0]       i_opcode,
    input  wire logic [31:0]      i_key,
    input  wire logic [31:0]      i_value,
    input  wire t_cmd             i_cmd,
    output t_sts                  o_sts,
    input  wire logic             i_out_ready,
    output logic                  o_out_valid,
    output logic [31:0]           o_found_value,
    output logic [1:0]            o_status,
    output logic                  o_last,
    output logic [5:0]            o_entry_count
);

    localparam int DW = $clog2(MAX_BUCKETS + 1);
    localparam int BW = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
    localparam int NW = $clog2(POOL_NODES + 1);
    localparam int AW = (POOL_NODES > 1) ? $clog2(POOL_NODES) : 1;
    localparam logic [NW-1:0] NIL = NW'(POOL_NODES);
    localparam logic [DW-1:0] MB_D = DW'(MAX_BUCKETS);
    localparam logic [BW-1:0] LAST_B = BW'(MAX_BUCKETS - 1);

    // Configuration and latched beat
    logic [CFG_W-1:0] r_cfg;
    logic [1:0]       r_op;
    logic [31:0]      r_key, r_val;

    // Modulo unit
    logic [31:0]   r_mag;
    logic [DW-1:0] r_rem, r_m, n_rem, w_m;
    logic [5:0]    r_bits;
    logic [DW:0]   w_try;

    // Walk and pool state
    logic [BW-1:0] r_clr;
    logic [NW-1:0] r_p, r_prev, r_steps, r_free;
    logic [5:0]    r_cnt, n_cnt;
    logic [31:0]   r_pend;
    logic          r_have;

    // Memories and their read registers
    logic [NW-1:0] m_heads [MAX_BUCKETS];
    logic [31:0]   m_keys  [POOL_NODES];
    logic [31:0]   m_vals  [POOL_NODES];
    logic [NW-1:0] m_links [POOL_NODES];
    logic [POOL_NODES-1:0] r_lvld;
    logic [NW-1:0] r_head_q, r_lraw_q, r_lidx_q, w_link_q;
    logic          r_lv_q;
    logic [31:0]   r_key_q, r_val_q;
    logic [BW-1:0] w_bkt;
    logic [AW-1:0] w_laddr;

    // Output register
    logic        r_ovld;
    logic [31:0] r_oval;
    logic [1:0]  r_ost;
    logic        r_olast;
    logic [5:0]  r_ocnt;

    // Effective modulus: zero reads as one, saturate at the bucket limit
    always_comb begin
        if (r_cfg == '0) w_m = DW'(1);
        else if (int'(r_cfg) > MAX_BUCKETS) w_m = MB_D;
        else w_m = DW'(r_cfg);
    end

    // One restoring step: shift in a bit, subtract when it fits
    assign w_try = {r_rem, r_mag[31]};
    always_comb begin
        if (w_try >= {1'b0, r_m}) n_rem = DW'(w_try - {1'b0, r_m});
        else n_rem = w_try[DW-1:0];
    end
    assign w_bkt = r_rem[BW-1:0];

    // Config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= BUCKET_RESET;
        end else if (i_cfg_wr_en) begin
            r_cfg <= i_cfg_wr_data;
        end
    end

    // Beat latch and modulo iteration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bits <= '0;
        end else if (i_cmd.accept) begin
            r_op   <= i_opcode;
            r_key  <= i_key;
            r_val  <= i_value;
            r_mag  <= i_key[31] ? (32'd0 - i_key) : i_key;
            r_m    <= w_m;
            r_rem  <= '0;
            r_bits <= '0;
        end else if (i_cmd.mod_step) begin
            r_rem  <= n_rem;
            r_mag  <= {r_mag[30:0], 1'b0};
            r_bits <= r_bits + 6'd1;
        end
    end

    // Entry count after this cycle's update
    always_comb begin
        n_cnt = r_cnt;
        if (i_cmd.add_wr) n_cnt = r_cnt + 6'd1;
        else if (i_cmd.rem_b) n_cnt = r_cnt - 6'd1;
    end

    // Control state of the pool and walk
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr  <= '0;
            r_free <= '0;
            r_cnt  <= '0;
            r_have <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            if (i_cmd.clr_step) r_clr <= r_clr + BW'(1);
            if (i_cmd.add_wr) r_free <= w_link_q;
            else if (i_cmd.rem_b) r_free <= r_p;
            if (i_cmd.walk_init) r_have <= 1'b0;
            else if (i_cmd.set_pend) r_have <= 1'b1;
        end
    end

    // Walk pointers
    always_ff @(posedge i_clk) begin
        if (i_cmd.walk_init) begin
            r_p     <= r_head_q;
            r_prev  <= NIL;
            r_steps <= '0;
        end else if (i_cmd.adv) begin
            r_prev  <= r_p;
            r_p     <= w_link_q;
            r_steps <= r_steps + NW'(1);
        end
        if (i_cmd.set_pend) r_pend <= r_val_q;
    end

    // Bucket head memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_step) m_heads[r_clr] <= NIL;
        else if (i_cmd.add_wr) m_heads[w_bkt] <= r_free;
        else if (i_cmd.rem_a && r_prev == NIL) m_heads[w_bkt] <= w_link_q;
        if (i_cmd.rd_head) r_head_q <= m_heads[w_bkt];
    end

    // Key and value memories
    always_ff @(posedge i_clk) begin
        if (i_cmd.add_wr) begin
            m_keys[r_free[AW-1:0]] <= r_key;
            m_vals[r_free[AW-1:0]] <= r_val;
        end
        if (i_cmd.rd_node) begin
            r_key_q <= m_keys[r_p[AW-1:0]];
            r_val_q <= m_vals[r_p[AW-1:0]];
        end
    end

    // Link memory; an unwritten entry reads as the next node (free list order)
    assign w_laddr = i_cmd.rd_node ? r_p[AW-1:0] : r_free[AW-1:0];
    always_ff @(posedge i_clk) begin
        if (i_cmd.add_wr) m_links[r_free[AW-1:0]] <= r_head_q;
        else if (i_cmd.rem_a && r_prev != NIL) m_links[r_prev[AW-1:0]] <= w_link_q;
        else if (i_cmd.rem_b) m_links[r_p[AW-1:0]] <= r_free;
        if (i_cmd.rd_head || i_cmd.rd_node) begin
            r_lraw_q <= m_links[w_laddr];
            r_lv_q   <= r_lvld[w_laddr];
            r_lidx_q <= NW'(w_laddr);
        end
    end
    assign w_link_q = r_lv_q ? r_lraw_q : (r_lidx_q + NW'(1));

    // Link valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lvld <= '0;
        end else begin
            if (i_cmd.add_wr) r_lvld[r_free[AW-1:0]] <= 1'b1;
            else if (i_cmd.rem_a && r_prev != NIL) r_lvld[r_prev[AW-1:0]] <= 1'b1;
            else if (i_cmd.rem_b) r_lvld[r_p[AW-1:0]] <= 1'b1;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (i_cmd.emit) begin
            r_ovld <= 1'b1;
        end else if (i_out_ready) begin
            r_ovld <= 1'b0;
        end
    end
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_oval  <= i_cmd.emit_pend ? r_pend : 32'd0;
            r_ost   <= i_cmd.emit_st;
            r_olast <= i_cmd.emit_last;
            r_ocnt  <= n_cnt;
        end
    end

    assign o_out_valid   = r_ovld;
    assign o_found_value = r_oval;
    assign o_status      = r_ost;
    assign o_last        = r_olast;
    assign o_entry_count = r_ocnt;

    // Status to the controller
    always_comb begin
        o_sts.clr_done  = (r_clr == LAST_B);
        o_sts.mod_done  = r_bits[5];
        o_sts.out_busy  = r_ovld && !i_out_ready;
        o_sts.op        = r_op;
        o_sts.free_nil  = (r_free == NIL);
        o_sts.walk_end  = (r_p == NIL) || (r_steps == NIL);
        o_sts.key_eq    = (r_key_q == r_key);
        o_sts.val_eq    = (r_val_q == r_val);
        o_sts.have_pend = r_have;
    end

endmodule
`default_nettype wire

[src/chained_hash_multimap.sv]
// Top level of the chained hash multimap: stream ports, controller and datapath.
// Processing: bit-serial modulo of the key, bucket head read and dispatch; search and
//   remove then walk the chain node by node, remove stopping at the matching node.
//   Output back-pressure adds stalls.
// Throughput: one beat at a time; next beat accepted once the last result is loaded.
// Reset: synchronous active low; a clearing pass over all MAX_BUCKETS bucket heads
//   empties them, during which no beat is accepted.
`timescale 1ns / 1ps
`default_nettype none
module chained_hash_multimap
    import hcm_pkg::*;
#(
    parameter int MAX_BUCKETS = 16,
    parameter int POOL_NODES  = 32
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_wr_en,
    input  wire logic [CFG_W-1:0] i_cfg_wr_data,  // bucket_count
    input  wire logic             i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  wire logic [71:0]      i_s_axis_tdata,  // opcode[1:0], key[33:2], value[65:34]
    output logic                  o_m_axis_tvalid,
    input  wire logic             i_m_axis_tready,
    output logic [39:0]           o_m_axis_tdata,  // found_value[31:0], status[33:32],
                                                   // entry_count[39:34]
    output logic                  o_m_axis_tlast
);

    t_cmd        w_cmd;
    t_sts        w_sts;
    logic [31:0] w_val;
    logic [1:0]  w_st;
    logic [5:0]  w_cnt;

    hcm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    hcm_dp #(
        .MAX_BUCKETS (MAX_BUCKETS),
        .POOL_NODES  (POOL_NODES)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_opcode      (i_s_axis_tdata[1:0]),
        .i_key         (i_s_axis_tdata[33:2]),
        .i_value       (i_s_axis_tdata[65:34]),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_out_ready   (i_m_axis_tready),
        .o_out_valid   (o_m_axis_tvalid),
        .o_found_value (w_val),
        .o_status      (w_st),
        .o_last        (o_m_axis_tlast),
        .o_entry_count (w_cnt)
    );

    assign o_m_axis_tdata = {w_cnt, w_st, w_val};

endmodule
`default_nettype wire

[tb/sv/chained_hash_multimap_test.sv]
// Self-checking testbench for the chained hash multimap: directed and random stream traffic.
`timescale 1ns / 1ps
module chained_hash_multimap_test
    import hcm_pkg::*;
;

    localparam int NBKT  = 16;
    localparam int NPOOL = 32;
    localparam int NIL   = NPOOL;
    localparam int LIMIT_CYCLES = 400000;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [31:0] found_value;
        logic [1:0]  status;
        logic        last;
        logic [5:0]  entry_count;
    } t_result;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_wr_en = 1'b0;
    logic [CFG_W-1:0]  i_cfg_wr_data = '0;
    logic              i_s_axis_tvalid = 1'b0;
    logic              o_s_axis_tready;
    logic [71:0]       i_s_axis_tdata = '0;
    logic              o_m_axis_tvalid;
    logic              i_m_axis_tready = 1'b0;
    logic [39:0]       o_m_axis_tdata;
    logic              o_m_axis_tlast;

    chained_hash_multimap i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_wr_en(i_cfg_wr_en), .i_cfg_wr_data(i_cfg_wr_data),
        .i_s_axis_tvalid(i_s_axis_tvalid), .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata(i_s_axis_tdata),
        .o_m_axis_tvalid(o_m_axis_tvalid), .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata(o_m_axis_tdata), .o_m_axis_tlast(o_m_axis_tlast)
    );

    always #5 i_clk = ~i_clk;

    // Shadow copy of the multimap state
    logic [4:0]  mdl_buckets;
    int          mdl_head[NBKT];
    logic [31:0] mdl_key[NPOOL];
    logic [31:0] mdl_val[NPOOL];
    int          mdl_link[NPOOL];
    int          mdl_free;
    logic [5:0]  mdl_pairs;

    t_result     expected_q[$];
    int          mismatches = 0;
    int          cycles = 0;
    bit          idle_on = 1'b1;
    int          hold_off = 0;
    int          rx_gap = 0;
    bit          rx_rest = 1'b0;

    function automatic int bucket_of(logic [31:0] key);
        logic [31:0] mag;
        int m;
        mag = key[31] ? (32'd0 - key) : key;
        m = mdl_buckets;
        if (m == 0) m = 1;
        if (m > NBKT) m = NBKT;
        return int'(mag % m);
    endfunction

    task automatic push_result(logic [31:0] v, logic [1:0] st, logic lst);
        t_result r;
        r.found_value = v; r.status = st; r.last = lst; r.entry_count = mdl_pairs;
        expected_q = {expected_q, r};
    endtask

    // Predict the results of one operation and update the shadow state
    task automatic predict_op(logic [1:0] op, logic [31:0] key, logic [31:0] val);
        int b, p, prev, steps, hits;
        b = bucket_of(key);
        hits = 0;
        case (op)
            OP_ADD: begin
                if (mdl_free >= NPOOL) begin
                    push_result(0, ST_FULL, 1'b1);
                end else begin
                    p = mdl_free;
                    mdl_free = mdl_link[p];
                    mdl_key[p] = key; mdl_val[p] = val;
                    mdl_link[p] = mdl_head[b];
                    mdl_head[b] = p;
                    mdl_pairs++;
                    push_result(0, ST_OK, 1'b1);
                end
            end
            OP_SEARCH: begin
                p = mdl_head[b];
                for (steps = 0; p < NPOOL && steps < NPOOL; steps++) begin
                    if (mdl_key[p] == key) begin
                        push_result(mdl_val[p], ST_OK, 1'b0);
                        hits++;
                    end
                    p = mdl_link[p];
                end
                if (hits == 0) push_result(0, ST_NOT_FOUND, 1'b1);
                else expected_q[$].last = 1'b1;
            end
            OP_REMOVE: begin
                prev = NIL;
                p = mdl_head[b];
                for (steps = 0; p < NPOOL && steps < NPOOL; steps++) begin
                    if (mdl_key[p] == key && mdl_val[p] == val) break;
                    prev = p;
                    p = mdl_link[p];
                end
                if (p < NPOOL && steps < NPOOL) begin
                    if (prev < NPOOL) mdl_link[prev] = mdl_link[p];
                    else mdl_head[b] = mdl_link[p];
                    mdl_link[p] = mdl_free;
                    mdl_free = p;
                    mdl_pairs--;
                    push_result(0, ST_OK, 1'b1);
                end else begin
                    push_result(0, ST_NOT_FOUND, 1'b1);
                end
            end
            default: push_result(0, ST_NOT_FOUND, 1'b1);
        endcase
    endtask

    // Random idle burst on the sender side
    task automatic sender_gap();
        int n;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, 4);
            repeat (n) @(negedge i_clk);
        end
    endtask

    // Send one beat and predict its results when it is accepted
    task automatic send_op(logic [1:0] op, logic [31:0] key, logic [31:0] val);
        sender_gap();
        i_s_axis_tdata = {6'd0, val, key, op};
        i_s_axis_tvalid = 1'b1;
        do @(posedge i_clk); while (!o_s_axis_tready);
        predict_op(op, key, val);
        @(negedge i_clk);
        i_s_axis_tvalid = 1'b0;
    endtask

    // Wait for all results, then let the block settle before a register write
    task automatic drain();
        while (expected_q.size() != 0) @(negedge i_clk);
        repeat (120) @(negedge i_clk);
    endtask

    task automatic write_buckets(logic [4:0] n);
        drain();
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= n;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        mdl_buckets = n;
    endtask

    function automatic logic [31:0] pick_key(int span);
        case ($urandom_range(0, 9))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0001;
            2: return 32'h8000_0000;
            default: return 32'($signed($urandom_range(0, 2 * span)) - span);
        endcase
    endfunction

    // Result checker
    always @(posedge i_clk) begin
        t_result got, exp_r;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got = {o_m_axis_tdata[31:0], o_m_axis_tdata[33:32], o_m_axis_tlast,
                   o_m_axis_tdata[39:34]};
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result beat %h", got);
            end else begin
                exp_r = expected_q.pop_front();
                if (got !== exp_r) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: exp val=%h st=%0d last=%0d cnt=%0d",
                                  " got val=%h st=%0d last=%0d cnt=%0d"},
                                 exp_r.found_value, exp_r.status, exp_r.last,
                                 exp_r.entry_count, got.found_value, got.status,
                                 got.last, got.entry_count);
                end
            end
        end
    end

    // Receiver: random stall bursts, plus a long hold-off on request
    always @(negedge i_clk) begin
        if (hold_off > 0) begin
            i_m_axis_tready <= 1'b0;
            hold_off <= hold_off - 1;
        end else if (rx_gap > 0) begin
            i_m_axis_tready <= 1'b0;
            rx_gap <= rx_gap - 1;
        end else if (idle_on && !rx_rest && $urandom_range(0, 4) == 0) begin
            i_m_axis_tready <= 1'b0;
            rx_gap <= $urandom_range(0, 3);
            rx_rest <= 1'b1;
        end else begin
            i_m_axis_tready <= 1'b1;
            rx_rest <= 1'b0;
        end
    end

    // Cycle watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic test_directed();
        send_op(OP_SEARCH, 32'd5, 32'd0);
        send_op(OP_REMOVE, 32'd5, 32'd1);
        send_op(OP_ADD, 32'h7FFF_FFFF, 32'h8000_0000);
        send_op(OP_ADD, 32'h8000_0001, 32'h7FFF_FFFF);
        send_op(OP_ADD, 32'h8000_0000, 32'hFFFF_FFFF);
        send_op(OP_ADD, 32'd5, 32'd11);
        send_op(OP_ADD, 32'd5, 32'd22);
        send_op(OP_ADD, 32'd15, 32'd33);
        send_op(OP_SEARCH, 32'd5, 32'hFFFF_FFFF);
        send_op(OP_SEARCH, 32'h8000_0000, 32'd0);
        send_op(OP_SEARCH, 32'h8000_0001, 32'd0);
        send_op(OP_REMOVE, 32'd5, 32'd11);
        send_op(OP_REMOVE, 32'd5, 32'd99);
        send_op(OP_SEARCH, 32'd5, 32'd0);
        send_op(OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_op(OP_UNUSED, 32'd0, 32'd0);
        send_op(OP_SEARCH, 32'd15, 32'd0);
    endtask

    // Fill the pool beyond its size, then empty part of it
    task automatic test_pool_full();
        int i;
        for (i = 0; i < NPOOL + 3; i++) send_op(OP_ADD, 32'(i % 7), 32'(i));
        send_op(OP_SEARCH, 32'd3, 32'd0);
        for (i = 0; i < NPOOL; i += 2) send_op(OP_REMOVE, 32'(i % 7), 32'(i));
    endtask

    // Bucket count extremes, including bucket count changes with stored pairs
    task automatic test_bucket_counts();
        write_buckets(5'd0);
        send_op(OP_SEARCH, 32'd1, 32'd0);
        send_op(OP_ADD, 32'd100, 32'd7);
        write_buckets(5'd31);
        send_op(OP_SEARCH, 32'd100, 32'd0);
        send_op(OP_ADD, 32'hFFFF_FFF1, 32'd8);
        write_buckets(5'd1);
        send_op(OP_SEARCH, 32'd100, 32'd0);
        write_buckets(5'd16);
        send_op(OP_SEARCH, 32'hFFFF_FFF1, 32'd0);
    endtask

    // Random well-formed traffic with a small key space, plus noise
    task automatic test_random(int count, logic [4:0] nb);
        int i;
        logic [31:0] k;
        write_buckets(nb);
        for (i = 0; i < count; i++) begin
            k = pick_key(12);
            case ($urandom_range(0, 19)) inside
                0: send_op(OP_UNUSED, $urandom, $urandom);
                [1:7]: send_op(OP_ADD, k, 32'($urandom_range(0, 3)));
                [8:13]: send_op(OP_SEARCH, k, $urandom);
                14: send_op(OP_ADD, $urandom, $urandom);
                default: send_op(OP_REMOVE, k, 32'($urandom_range(0, 3)));
            endcase
        end
    endtask

    // Receiver holds off while the sender keeps offering beats
    task automatic test_backpressure();
        int i;
        hold_off = 300;
        for (i = 0; i < 6; i++) send_op(OP_SEARCH, 32'($urandom_range(0, 4)), 32'd0);
        drain();
    endtask

    initial begin
        mdl_buckets = BUCKET_RESET;
        for (int i = 0; i < NBKT; i++) mdl_head[i] = NIL;
        for (int i = 0; i < NPOOL; i++) begin
            mdl_link[i] = i + 1; mdl_key[i] = '0; mdl_val[i] = '0;
        end
        mdl_free = 0;
        mdl_pairs = '0;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed();
        test_pool_full();
        test_bucket_counts();
        test_backpressure();
        test_random(55, 5'd10);
        test_random(35, 5'd3);
        idle_on = 1'b0;
        test_random(50, 5'd16);

        drain();
        if (mismatches == 0 && expected_q.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule

[filelist.f]
src/hcm_pkg.sv
src/hcm_ctrl.sv
src/hcm_dp.sv
src/chained_hash_multimap.sv
tb/sv/chained_hash_multimap_test.sv
